// ----- rtl/afpc_pkg.sv -----
// shared types and constants for the audio fifo with pcm conversion
package afpc_pkg;

  // default ring size, a power of two
  localparam int RING_DEPTH_DEF = 4096;

  // fixed field widths
  localparam int SAMPLE_W  = 32;
  localparam int FILL_W    = 13;
  localparam int OP_W      = 2;
  localparam int FMT_W     = 2;
  localparam int MANT_W    = 24;
  localparam int FULL_W    = 31;
  localparam int PROD_W    = MANT_W + FULL_W;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // full-scale magnitudes per wire format
  localparam logic [FULL_W-1:0] FULL_I32 = 31'h7FFF_FFFF;
  localparam logic [FULL_W-1:0] FULL_I24 = 31'd8388607;
  localparam logic [FULL_W-1:0] FULL_I16 = 31'd32767;

  // float32 constants
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_ONE      = 8'd127;
  localparam logic [7:0] EXP_SHIFT    = 8'd150;

  // register word index of wire_format
  localparam logic REG_WIRE_FORMAT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_F32 = 2'd0,
    FMT_I32 = 2'd1,
    FMT_I24 = 2'd2,
    FMT_I16 = 2'd3
  } fmt_t;

  // per-beat control that travels down the pipeline
  typedef struct packed {
    logic              accepted;
    logic              underrun;
    logic              word_en;
    logic [FILL_W-1:0] fill;
  } ctrl_t;

  // full-scale magnitude for a format
  function automatic logic [FULL_W-1:0] full_of(input fmt_t fmt);
    logic [FULL_W-1:0] f;
    case (fmt)
      FMT_I32: f = FULL_I32;
      FMT_I24: f = FULL_I24;
      FMT_I16: f = FULL_I16;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/afpc_ram.sv -----
// generic single-write, single-read ram with registered read data
module afpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/audio_fifo_with_pcm_conversion.sv -----
// audio sample ring buffer with float32 to pcm wire-format conversion
//
// input beats on s_*: s_tuser is the op (push, pop, flush, no-op), s_tdata
// the float32 sample used by a push. every input beat gives exactly one
// output beat on m_*: accepted and underrun flags in m_tuser, the wire word
// and the fill level after the beat in m_tdata.
// the wire format (float32 raw, int32, int24 in the top of 32, int16) is set
// through the apb port and is applied when a popped sample leaves the ring.
// a push to a full ring is dropped with accepted low; a pop from an empty
// ring returns zero with underrun high; a flush empties the ring.
// one beat is taken every cycle while s_tready is high: ring state updates
// at the input edge, the ram read is one stage, the scaling multiply one
// stage and shift/format the last.
// when the receiver stalls, the whole pipeline holds and s_tready drops only
// while the output register holds a beat that is not taken.
// reset empties the ring and sets the format to float32; ram contents are
// not cleared since a pop only reads entries already written.
module audio_fifo_with_pcm_conversion
  import afpc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input beats
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // [31:0] sample_bits
  input  logic [1:0]        s_tuser,   // [1:0] op
  // output beats
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // [31:0] wire_word, [44:32] fill_level, zero pad
  output logic [1:0]        m_tuser,   // [0] accepted, [1] underrun
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 1;

  // configuration register
  fmt_t wire_format;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wire_format <= FMT_F32;
    end else if (psel && penable && pwrite && paddr[2] == REG_WIRE_FORMAT) begin
      wire_format <= fmt_t'(pwdata[FMT_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIRE_FORMAT) begin
      prdata = APB_DW'(wire_format);
    end
  end

  // pipeline advance
  logic out_valid;
  logic move;
  logic in_acc;

  assign move     = !out_valid || m_tready;
  assign s_tready = move;
  assign in_acc   = s_tvalid && move;

  // ring pointers with one wrap bit
  logic [PW-1:0] write_index, write_index_next;
  logic [PW-1:0] read_index, read_index_next;
  logic [PW-1:0] fill_now, fill_after;
  op_t           op_in;
  logic          push_ok, pop_ok;
  ctrl_t         in_ctrl;

  assign op_in    = op_t'(s_tuser);
  assign fill_now = write_index - read_index;

  always_comb begin
    push_ok          = (op_in == OP_PUSH) && !fill_now[PW-1];
    pop_ok           = (op_in == OP_POP) && (fill_now != '0);
    write_index_next = write_index + PW'(push_ok);
    read_index_next  = read_index + PW'(pop_ok);
    if (op_in == OP_FLUSH) begin
      read_index_next = write_index;
    end
    fill_after       = write_index_next - read_index_next;
    in_ctrl.accepted = push_ok;
    in_ctrl.underrun = (op_in == OP_POP) && !pop_ok;
    in_ctrl.word_en  = pop_ok;
    in_ctrl.fill     = FILL_W'(fill_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else if (in_acc) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
    end
  end

  // sample ring
  logic [SAMPLE_W-1:0] ram_rdata;

  afpc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc && push_ok),
    .waddr (write_index[AW-1:0]),
    .wdata (s_tdata),
    .re    (move),
    .raddr (read_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1: ram data arrives, decode float and multiply by full scale
  logic  s1_valid;
  ctrl_t s1_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (move) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s1_ctrl <= in_ctrl;
    end
  end

  logic              f_neg, f_nan, f_sat;
  logic [7:0]        f_exp, f_exp_eff, f_sh;
  logic [22:0]       f_man;
  logic [MANT_W-1:0] f_mant;
  logic [PROD_W-1:0] f_prod;

  always_comb begin
    f_exp     = ram_rdata[30:23];
    f_man     = ram_rdata[22:0];
    f_nan     = (f_exp == EXP_ALL_ONES) && (f_man != '0);
    f_sat     = f_nan || (f_exp >= EXP_ONE);
    f_neg     = ram_rdata[31] && !f_nan;
    f_mant    = {(f_exp != '0), f_man};
    f_exp_eff = (f_exp != '0) ? f_exp : 8'd1;
    f_sh      = EXP_SHIFT - f_exp_eff;
    f_prod    = PROD_W'(f_mant) * PROD_W'(full_of(wire_format));
  end

  // stage 2 registers
  logic                s2_valid;
  ctrl_t               s2_ctrl;
  logic [SAMPLE_W-1:0] s2_raw;
  logic [PROD_W-1:0]   s2_prod;
  logic [7:0]          s2_sh;
  logic                s2_sat, s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (move) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s2_ctrl <= s1_ctrl;
      s2_raw  <= ram_rdata;
      s2_prod <= f_prod;
      s2_sh   <= f_sh;
      s2_sat  <= f_sat;
      s2_neg  <= f_neg;
    end
  end

  // stage 2: truncating shift, sign and wire packing
  logic [PROD_W-1:0]   shifted;
  logic [31:0]         mag, signed_word;
  logic [SAMPLE_W-1:0] word;

  always_comb begin
    shifted     = s2_prod >> s2_sh;
    mag         = s2_sat ? 32'(full_of(wire_format)) : shifted[31:0];
    signed_word = s2_neg ? (32'd0 - mag) : mag;
    case (wire_format)
      FMT_I32: word = signed_word;
      FMT_I24: word = {signed_word[23:0], 8'd0};
      FMT_I16: word = {16'd0, signed_word[15:0]};
      default: word = s2_raw;
    endcase
    if (!s2_ctrl.word_en) begin
      word = '0;
    end
  end

  // output register
  ctrl_t               out_ctrl;
  logic [SAMPLE_W-1:0] out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_ctrl <= s2_ctrl;
      out_word <= word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_ctrl.fill, out_word};
  assign m_tuser  = {out_ctrl.underrun, out_ctrl.accepted};

endmodule
